[sv/dhd_pkg.sv]
// shared types and constants of the diagonal to hacked diagonal compactor
package dhd_pkg;

  localparam int VALUE_W    = 64;
  localparam int OFFSET_W   = 17;
  localparam int POS_W      = 26;
  localparam int SLOT_W     = 21;
  localparam int HEIGHT_W   = 22;
  localparam int ROW_W      = 6;
  localparam int ROWCFG_W   = 17;
  localparam int DIAGCFG_W  = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_COUNT = 1'b1;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // one closed slice handed from front to back
  typedef struct packed {
    logic                       keep;
    logic                       bank;
    logic [HEIGHT_W-1:0]        slot;
    logic signed [OFFSET_W-1:0] offset;
    logic [ROW_W-1:0]           rows;
    logic                       hack_end;
    logic [HEIGHT_W-1:0]        height;
  } dhd_cmd_t;

  // bank handed back once drained
  typedef struct packed {
    logic valid;
    logic bank;
  } dhd_rel_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROWS,
    BK_MARK
  } bk_state_e;

  // zero acts as one, anything above the bound saturates
  function automatic logic [31:0] sat_count(logic [31:0] v, logic [31:0] hi);
    logic [31:0] r;
    r = v;
    if (r == 32'd0) r = 32'd1;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

[sv/dhd_intf.sv]
// request channel interfaces for elements in and results out
interface dhd_in_if;
  import dhd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [VALUE_W-1:0]         elem_value;
  logic signed [OFFSET_W-1:0] diag_offset;
  modport source (output valid, elem_value, diag_offset, input ready);
  modport sink   (input valid, elem_value, diag_offset, output ready);
endinterface

interface dhd_out_if;
  import dhd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       item_kind;
  logic [VALUE_W-1:0]         out_value;
  logic [POS_W-1:0]           out_position;
  logic [SLOT_W-1:0]          out_slot;
  logic signed [OFFSET_W-1:0] out_diag_offset;
  logic [HEIGHT_W-1:0]        running_height;
  logic                       last;
  modport source (output valid, item_kind, out_value, out_position, out_slot,
                  out_diag_offset, running_height, last, input ready);
  modport sink   (input valid, item_kind, out_value, out_position, out_slot,
                  out_diag_offset, running_height, last, output ready);
endinterface

[sv/dhd_sbuf.sv]
// two-bank slice buffer, one write and one registered read port
module dhd_sbuf #(
  parameter int VB = 64,
  parameter int AW = 5
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW:0]   wr_addr_i,
  input  logic [VB-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW:0]   rd_addr_i,
  output logic [VB-1:0] rd_data_o
);

  logic [VB-1:0] mem [2**(AW+1)];
  logic [VB-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/dhd_cmdq.sv]
// short first-word-fall-through queue of slice commands
module dhd_cmdq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dhd_pkg::dhd_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output dhd_pkg::dhd_cmd_t cmd_o
);
  import dhd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  dhd_cmd_t      slots_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[sv/dhd_front.sv]
// front end: takes elements, fills the slice buffer, closes slices
module dhd_front #(
  parameter int HACK_SIZE     = 32,
  parameter int VB            = 64,
  parameter int MAX_ROWS      = 65536,
  parameter int MAX_DIAGONALS = 1024,
  parameter int AW            = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dhd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dhd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  dhd_in_if.sink                           in_i,
  output logic                             wr_en_o,
  output logic [AW:0]                      wr_addr_o,
  output logic [VB-1:0]                    wr_data_o,
  output logic                             push_o,
  output dhd_pkg::dhd_cmd_t                cmd_o,
  input  logic                             full_i,
  input  dhd_pkg::dhd_rel_t                rel_i
);
  import dhd_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int DW = $clog2(MAX_DIAGONALS + 1);

  logic [ROWCFG_W-1:0]  row_count_q;
  logic [DIAGCFG_W-1:0] diag_count_q;
  logic [RW-1:0]        rows_left_q, rows_left_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [DW-1:0]        diag_q, diag_d;
  logic [HEIGHT_W-1:0]  kept_q, kept_d;
  logic                 nz_q, nz_d;
  logic                 bank_q, bank_d;
  logic [1:0]           busy_q, busy_d;

  logic [VB-1:0]        value;
  logic                 accept;
  logic [ROW_W-1:0]     slice_rows;
  logic [ROW_W:0]       row_nx;
  logic [DW:0]          diag_nx;
  logic [DW-1:0]        eff_diags;
  logic [RW-1:0]        eff_rows;
  logic                 close, keep, hack_end, last_hack;
  logic [HEIGHT_W-1:0]  kept_nx;

  assign value     = in_i.elem_value[VB-1:0];
  assign in_i.ready = !busy_q[bank_q] && !full_i;
  assign accept    = in_i.valid && in_i.ready;

  assign eff_rows  = RW'(sat_count(32'(row_count_q), 32'(MAX_ROWS)));
  assign eff_diags = DW'(sat_count(32'(diag_count_q), 32'(MAX_DIAGONALS)));

  assign slice_rows = (32'(rows_left_q) < 32'(HACK_SIZE)) ? ROW_W'(rows_left_q)
                                                         : ROW_W'(HACK_SIZE);
  assign row_nx    = {1'b0, row_q} + 1'b1;
  assign close     = (row_nx >= {1'b0, slice_rows});
  assign keep      = nz_q || (value != '0);
  assign kept_nx   = kept_q + HEIGHT_W'(keep);
  assign diag_nx   = {1'b0, diag_q} + 1'b1;
  assign hack_end  = (diag_nx >= {1'b0, eff_diags});
  assign last_hack = (32'(rows_left_q) <= 32'(HACK_SIZE));

  assign wr_en_o   = accept;
  assign wr_addr_o = {bank_q, row_q[AW-1:0]};
  assign wr_data_o = value;

  assign push_o          = accept && close && (keep || hack_end);
  assign cmd_o.keep      = keep;
  assign cmd_o.bank      = bank_q;
  assign cmd_o.slot      = kept_q;
  assign cmd_o.offset    = in_i.diag_offset;
  assign cmd_o.rows      = slice_rows;
  assign cmd_o.hack_end  = hack_end;
  assign cmd_o.height    = kept_nx;

  always_comb begin
    rows_left_d = rows_left_q;
    row_d       = row_q;
    diag_d      = diag_q;
    kept_d      = kept_q;
    nz_d        = nz_q;
    bank_d      = bank_q;
    busy_d      = busy_q;
    if (rel_i.valid) busy_d[rel_i.bank] = 1'b0;
    if (cfg_we_i) begin
      // a write restarts the traversal
      row_d  = '0;
      diag_d = '0;
      kept_d = '0;
      nz_d   = 1'b0;
      bank_d = 1'b0;
      if (cfg_idx_i == CFG_ROW_COUNT) begin
        rows_left_d = RW'(sat_count(32'(cfg_data_i), 32'(MAX_ROWS)));
      end else begin
        rows_left_d = eff_rows;
      end
    end else if (accept) begin
      if (!close) begin
        row_d = row_nx[ROW_W-1:0];
        nz_d  = keep;
      end else begin
        row_d  = '0;
        nz_d   = 1'b0;
        kept_d = kept_nx;
        if (keep) begin
          busy_d[bank_q] = 1'b1;
          bank_d         = !bank_q;
        end
        if (!hack_end) begin
          diag_d = diag_nx[DW-1:0];
        end else begin
          diag_d = '0;
          if (last_hack) begin
            rows_left_d = eff_rows;
            kept_d      = '0;
          end else begin
            rows_left_d = rows_left_q - RW'(HACK_SIZE);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q  <= ROWCFG_W'(1);
      diag_count_q <= DIAGCFG_W'(1);
      rows_left_q  <= RW'(1);
      row_q        <= '0;
      diag_q       <= '0;
      kept_q       <= '0;
      nz_q         <= 1'b0;
      bank_q       <= 1'b0;
      busy_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROW_COUNT:  row_count_q  <= cfg_data_i[ROWCFG_W-1:0];
          CFG_DIAG_COUNT: diag_count_q <= cfg_data_i[DIAGCFG_W-1:0];
          default: ;
        endcase
      end
      rows_left_q <= rows_left_d;
      row_q       <= row_d;
      diag_q      <= diag_d;
      kept_q      <= kept_d;
      nz_q        <= nz_d;
      bank_q      <= bank_d;
      busy_q      <= busy_d;
    end
  end

endmodule

[sv/dhd_back.sv]
// back end: streams kept slices and end of hack markers
module dhd_back #(
  parameter int HACK_SIZE = 32,
  parameter int VB        = 64,
  parameter int AW        = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  dhd_pkg::dhd_cmd_t cmd_i,
  output logic              pop_o,
  output dhd_pkg::dhd_rel_t rel_o,
  output logic              rd_en_o,
  output logic [AW:0]       rd_addr_o,
  input  logic [VB-1:0]     rd_data_i,
  dhd_out_if.source         out_o
);
  import dhd_pkg::*;

  bk_state_e                  state_q, state_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic [POS_W-1:0]           pos_q, pos_d;

  logic                       o_valid_q, o_valid_d;
  logic                       o_kind_q;
  logic [POS_W-1:0]           o_pos_q;
  logic [SLOT_W-1:0]          o_slot_q;
  logic signed [OFFSET_W-1:0] o_off_q;
  logic [HEIGHT_W-1:0]        o_height_q;
  logic                       o_last_q;

  logic                       adv, issue_row, issue_mark, last_row;

  assign adv      = !o_valid_q || out_o.ready;
  assign last_row = (row_q == cmd_i.rows - 1'b1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (cmd_valid_i) state_d = cmd_i.keep ? BK_ROWS : BK_MARK;
      BK_ROWS: if (adv && last_row) state_d = cmd_i.hack_end ? BK_MARK : BK_IDLE;
      BK_MARK: if (adv) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    issue_row  = 1'b0;
    issue_mark = 1'b0;
    unique case (state_q)
      BK_ROWS: issue_row  = adv;
      BK_MARK: issue_mark = adv;
      default: ;
    endcase
  end

  assign pop_o     = (issue_row && last_row && !cmd_i.hack_end) || issue_mark;
  assign rel_o.valid = pop_o && cmd_i.keep;
  assign rel_o.bank  = cmd_i.bank;
  assign rd_en_o   = issue_row;
  assign rd_addr_o = {cmd_i.bank, row_q[AW-1:0]};

  always_comb begin
    row_d = row_q;
    pos_d = pos_q;
    if (state_q == BK_IDLE) begin
      row_d = '0;
      pos_d = POS_W'(cmd_i.slot) * POS_W'(HACK_SIZE);
    end else if (issue_row) begin
      row_d = row_q + 1'b1;
      pos_d = pos_q + 1'b1;
    end
  end

  assign o_valid_d = (issue_row || issue_mark) ? 1'b1 :
                     (out_o.ready ? 1'b0 : o_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    pos_q <= pos_d;
    if (issue_row) begin
      o_kind_q   <= KIND_VALUE;
      o_pos_q    <= pos_q;
      o_slot_q   <= cmd_i.slot[SLOT_W-1:0];
      o_off_q    <= cmd_i.offset;
      o_height_q <= cmd_i.slot + 1'b1;
      o_last_q   <= last_row && !cmd_i.hack_end;
    end else if (issue_mark) begin
      o_kind_q   <= KIND_MARKER;
      o_pos_q    <= '0;
      o_slot_q   <= '0;
      o_off_q    <= '0;
      o_height_q <= cmd_i.height;
      o_last_q   <= 1'b1;
    end
  end

  assign out_o.valid           = o_valid_q;
  assign out_o.item_kind       = o_kind_q;
  assign out_o.out_value       = (o_kind_q == KIND_VALUE) ? VALUE_W'(rd_data_i) : '0;
  assign out_o.out_position    = o_pos_q;
  assign out_o.out_slot        = o_slot_q;
  assign out_o.out_diag_offset = o_off_q;
  assign out_o.running_height  = o_height_q;
  assign out_o.last            = o_last_q;

endmodule

[sv/dia_to_hacked_dia_compactor_core.sv]
// top level of the diagonal to hacked diagonal compactor
//
//  channel  | dir | carries
//  ---------+-----+-----------------------------------------------------------
//  in_i     | in  | one diagonal element per request: value and diagonal offset
//  out_o    | out | kept value with compacted address, or end of hack marker
//  cfg_*_i  | in  | register write: row_count (index 0), diagonal_count (index 1)
//
//  a slice of n rows takes n elements at the input, one element per cycle unless stalled
//  a kept slice then leaves as n result requests, one per cycle from the slice
//  buffer read port while the output is ready, with a sequencer idle state per command
//  reset leaves row, diagonal and slot counters at zero and both registers at one; no clearing pass
//  the input stalls while the bank it would fill still drains, or the queue is full
module dia_to_hacked_dia_compactor_core #(
  parameter int HACK_SIZE     = 32,
  parameter int VALUE_BITS    = 64,
  parameter int MAX_ROWS      = 65536,
  parameter int MAX_DIAGONALS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dhd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dhd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dhd_in_if.sink                         in_i,
  dhd_out_if.source                      out_o
);
  import dhd_pkg::*;

  // row index bits within one bank
  localparam int AW = (HACK_SIZE > 1) ? $clog2(HACK_SIZE) : 1;

  // front to slice buffer
  logic                  wr_en;
  logic [AW:0]           wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  // back to slice buffer
  logic                  rd_en;
  logic [AW:0]           rd_addr;
  logic [VALUE_BITS-1:0] rd_data;

  // command queue between front and back
  logic     push, full, pop, cmd_valid;
  dhd_cmd_t cmd_in, cmd_head;
  dhd_rel_t rel;

  dhd_front #(
    .HACK_SIZE     (HACK_SIZE),
    .VB            (VALUE_BITS),
    .MAX_ROWS      (MAX_ROWS),
    .MAX_DIAGONALS (MAX_DIAGONALS),
    .AW            (AW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .full_i     (full),
    .rel_i      (rel)
  );

  // two banks so the next slice fills while the last one drains
  dhd_sbuf #(
    .VB (VALUE_BITS),
    .AW (AW)
  ) u_sbuf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dhd_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  dhd_back #(
    .HACK_SIZE (HACK_SIZE),
    .VB        (VALUE_BITS),
    .AW        (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .rel_o       (rel),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_o       (out_o)
  );

endmodule
